// ===== design/sqes_pkg.sv =====
// Shared types and character codes for the shell quote escape stripper.
package sqes_pkg;

  localparam logic [7:0] CH_SINGLE = 8'h27;
  localparam logic [7:0] CH_DOUBLE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int unsigned MAX_RES = 3;

  localparam logic STYLE_SINGLE = 1'b0;
  localparam logic STYLE_DOUBLE = 1'b1;

  // one result item as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_item_t;

  // all results caused by one input byte; last_idx is the count minus one
  typedef struct packed {
    logic [1:0]            last_idx;
    res_item_t [MAX_RES-1:0] items;
  } entry_t;

endpackage

// ===== design/sqes_front.sv =====
// Front end: quote/escape/space parsing state and result grouping per input byte.
module sqes_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            push,
  output sqes_pkg::entry_t entry
);
  import sqes_pkg::*;

  logic       style_r;
  logic       quoted_r, quoted_nxt;
  logic       esc_r, esc_nxt;
  logic       pps_r, pps_nxt;
  logic       held_r, held_nxt;
  logic       do_bs, do_ch;
  logic [1:0] n;
  logic [7:0] qch;
  res_item_t [MAX_RES-1:0] items;

  assign cfg_ready = 1'b1;
  assign qch = (style_r == STYLE_DOUBLE) ? CH_DOUBLE : CH_SINGLE;

  always_comb begin
    quoted_nxt = quoted_r;
    esc_nxt    = esc_r;
    pps_nxt    = pps_r;
    held_nxt   = held_r;
    do_bs      = 1'b0;
    do_ch      = 1'b0;
    items      = '0;
    n          = 2'd0;

    if (esc_r) begin
      // escaped byte always follows double-quote escape rules
      esc_nxt = 1'b0;
      pps_nxt = 1'b0;
      if (in_byte != CH_NUL) begin
        do_ch = 1'b1;
        do_bs = quoted_r && (in_byte != CH_BSLASH) && (in_byte != CH_DOUBLE);
      end
    end else if (in_byte == qch) begin
      quoted_nxt = !quoted_r;
      pps_nxt    = 1'b0;
    end else if ((style_r == STYLE_DOUBLE) && (in_byte == CH_BSLASH)) begin
      esc_nxt = 1'b1;
      pps_nxt = 1'b0;
    end else if (quoted_r) begin
      do_ch   = 1'b1;
      pps_nxt = 1'b0;
    end else if (in_byte == CH_SPACE) begin
      do_ch   = !pps_r;
      pps_nxt = 1'b1;
    end else begin
      do_ch   = 1'b1;
      pps_nxt = 1'b0;
    end

    // a held space is released only when another character follows
    if (do_bs) begin
      if (held_nxt) begin
        items[n] = '{data: CH_SPACE, valid: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
      held_nxt = 1'b0;
      items[n] = '{data: CH_BSLASH, valid: 1'b1, last: 1'b0};
      n = n + 2'd1;
    end
    if (do_ch) begin
      if (held_nxt) begin
        items[n] = '{data: CH_SPACE, valid: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
      if (in_byte == CH_SPACE) begin
        held_nxt = 1'b1;
      end else begin
        held_nxt = 1'b0;
        items[n] = '{data: in_byte, valid: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
    end

    if (in_last) begin
      if (n != 2'd0) begin
        items[n - 2'd1].last = 1'b1;
      end else begin
        items[0] = '{data: CH_NUL, valid: 1'b0, last: 1'b1};
        n = 2'd1;
      end
      quoted_nxt = 1'b0;
      esc_nxt    = 1'b0;
      pps_nxt    = 1'b0;
      held_nxt   = 1'b0;
    end
  end

  assign push           = accept && (n != 2'd0);
  assign entry.items    = items;
  assign entry.last_idx = n - 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r  <= STYLE_DOUBLE;
      quoted_r <= 1'b0;
      esc_r    <= 1'b0;
      pps_r    <= 1'b0;
      held_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        style_r <= cfg_data;
      end
      if (accept) begin
        quoted_r <= quoted_nxt;
        esc_r    <= esc_nxt;
        pps_r    <= pps_nxt;
        held_r   <= held_nxt;
      end
    end
  end

endmodule

// ===== design/sqes_fifo.sv =====
// Small queue of result groups between the parser and the output serializer.
module sqes_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sqes_pkg::entry_t wdata,
  input  logic             pop,
  output sqes_pkg::entry_t rdata,
  output logic             full,
  output logic             empty
);
  import sqes_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign rdata = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== design/sqes_back.sv =====
// Back end: walks each queued group one result at a time into the output register.
module sqes_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sqes_pkg::entry_t head,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);
  import sqes_pkg::*;

  logic [1:0] idx_r;
  logic       tvalid_r;
  res_item_t  item_r;
  logic       load;

  assign load = !q_empty && (!tvalid_r || out_tready);
  assign pop  = load && (idx_r == head.last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 2'd0;
      tvalid_r <= 1'b0;
    end else begin
      if (load) begin
        tvalid_r <= 1'b1;
        idx_r    <= pop ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= head.items[idx_r];
    end
  end

  assign out_tvalid = tvalid_r;
  assign out_tdata  = item_r.data;
  assign out_tuser  = item_r.valid;
  assign out_tlast  = item_r.last;

endmodule

// ===== design/shell_quote_escape_stripper_core.sv =====
// An accepted byte's results are written into the result queue and then loaded into the output register.
// Throughput: one input byte per cycle while the result queue has room; results
// leave one per cycle while out_tready is high, and one byte can make up to three results.
// The queue depth (QUEUE_DEPTH groups) absorbs these bursts.
// Reset (rst_n low, synchronous) clears parse state, queue and output; quote_style -> 1.
module shell_quote_escape_stripper_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,    // quote_style
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tuser,   // [0] out_valid
  output logic       out_tlast
);
  import sqes_pkg::*;

  logic   accept, push, pop, q_full, q_empty;
  entry_t wentry, head;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  sqes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .push      (push),
    .entry     (wentry)
  );

  sqes_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wentry),
    .pop   (pop),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  sqes_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/sqes_checker.sv =====
// Port-level checks for the shell quote escape stripper, bound to the top level.
module sqes_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       cfg_data,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // bare end marker carries no byte and closes the string
  a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == 8'h00))
    else $error("bare marker malformed");

  // output is empty right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind shell_quote_escape_stripper_core sqes_checker u_sqes_checker (.*);
